// File: hdl/msp_pkg.sv
// Shared constants for the matrix saddle point finder.
// No dependencies; imported by the top level.
package msp_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 7;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Register indexes on the configuration port
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    localparam int CMEM_W = DATA_W + ROW_W;

endpackage

// File: hdl/matrix_saddle_point_finder.sv
// Matrix saddle point finder: streams a matrix row-major, reports saddle points.
// Depends on msp_pkg and msp_ram.
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ----------------------------------
//  in        sink       i_in_valid / o_in_stall   i_element_value
//  out       source     o_out_valid / i_out_stall o_found, o_point_row, o_point_col,
//                                                 o_last
//  config    APB slave  psel/penable/pwrite       paddr, pwdata, prdata (row, col)
//
// Elements are taken one word per cycle in the accumulate state; the input stalls in
// every other state. Each does one read-modify-write of the column store (read at
// accept, write in the following cycle, forwarded when the same column comes
// back-to-back). After the last element: a drain state, then the report scan steps
// through each column (column store read, row store read, check), then the final
// word. Output stalls hold the scan. Reset is synchronous, active low; stores are
// not cleared, every entry is written within a matrix before it is read. A register
// write restarts the matrix.
module matrix_saddle_point_finder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // element input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [msp_pkg::DATA_W-1:0]   i_element_value,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_found,
    output logic [msp_pkg::SIZE_W-1:0]          o_point_row,
    output logic [msp_pkg::SIZE_W-1:0]          o_point_col,
    output logic                                o_last,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msp_pkg::APB_AW-1:0]          paddr,
    input  logic [msp_pkg::APB_DW-1:0]          pwdata,
    output logic [msp_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import msp_pkg::*;

    typedef enum logic [2:0] {
        S_ACC,
        S_DRAIN,
        S_COL,
        S_ROW,
        S_CHK,
        S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [SIZE_W-1:0] r_row_count;
    logic [SIZE_W-1:0] r_col_count;
    logic              cfg_wr;
    logic [ROW_W-1:0]  last_row;
    logic [COL_W-1:0]  last_col;

    // element position and running row minimum
    logic [ROW_W-1:0]         r_row;
    logic [COL_W-1:0]         r_col;
    logic signed [DATA_W-1:0] r_min;
    logic [COL_W-1:0]         r_min_col;
    logic                     take_min;
    logic [COL_W-1:0]         n_min_col;
    logic                     acc;

    // column store update stage
    logic                     r_s1_vld;
    logic signed [DATA_W-1:0] r_s1_val;
    logic [ROW_W-1:0]         r_s1_row;
    logic [COL_W-1:0]         r_s1_col;
    logic                     r_fw_vld;
    logic [COL_W-1:0]         r_fw_addr;
    logic [CMEM_W-1:0]        r_fw_data;
    logic [CMEM_W-1:0]        cmem_rd;
    logic [CMEM_W-1:0]        cmem_cur;
    logic [CMEM_W-1:0]        cmem_wr_data;
    logic [COL_W-1:0]         cmem_rd_addr;
    logic                     upd;

    // row store
    logic                     rmem_we;
    logic [COL_W-1:0]         rmem_rd;
    logic [ROW_W-1:0]         rmem_rd_addr;

    // scan
    logic [COL_W-1:0]         r_x;
    logic [ROW_W-1:0]         r_mr;
    logic                     hit;
    logic                     out_free;
    logic                     chk_adv;
    logic                     r_pend_vld;
    logic [SIZE_W-1:0]        r_pend_row;
    logic [SIZE_W-1:0]        r_pend_col;

    // output register
    logic                     r_out_vld;
    logic                     r_found;
    logic [SIZE_W-1:0]        r_point_row;
    logic [SIZE_W-1:0]        r_point_col;
    logic                     r_last;

    // Clamp sizes: zero acts as one, anything above the maximum acts as the maximum.
    always_comb begin
        if (r_row_count == '0) begin
            last_row = '0;
        end else if (r_row_count > SIZE_W'(MAX_ROWS)) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(r_row_count - SIZE_W'(1));
        end
        if (r_col_count == '0) begin
            last_col = '0;
        end else if (r_col_count > SIZE_W'(MAX_COLS)) begin
            last_col = COL_W'(MAX_COLS - 1);
        end else begin
            last_col = COL_W'(r_col_count - SIZE_W'(1));
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COL_COUNT) ? APB_DW'(r_col_count) : APB_DW'(r_row_count);

    assign o_in_stall = (r_state != S_ACC);
    assign acc        = i_in_valid && !o_in_stall;

    // Row minimum: first column of a row always takes; ties keep the earlier column.
    assign take_min  = (r_col == '0) || (i_element_value < r_min);
    assign n_min_col = take_min ? r_col : r_min_col;

    // Column maximum update, in the cycle after the read was issued. The write of the
    // previous cycle is not visible in read data yet, so forward it.
    assign cmem_cur     = (r_fw_vld && (r_fw_addr == r_s1_col)) ? r_fw_data : cmem_rd;
    assign upd          = r_s1_vld && ((r_s1_row == '0) ||
                          (r_s1_val > $signed(cmem_cur[CMEM_W-1:ROW_W])));
    assign cmem_wr_data = {r_s1_val, r_s1_row};
    assign cmem_rd_addr = (r_state == S_ACC) ? r_col : r_x;

    msp_ram #(
        .WIDTH (CMEM_W),
        .DEPTH (MAX_COLS)
    ) u_col_mem (
        .i_clk     (i_clk),
        .i_we      (upd),
        .i_wr_addr (r_s1_col),
        .i_wr_data (cmem_wr_data),
        .i_rd_addr (cmem_rd_addr),
        .o_rd_data (cmem_rd)
    );

    // Record the column of the row minimum at the end of each row.
    assign rmem_we      = acc && (r_col == last_col);
    assign rmem_rd_addr = (r_state == S_ROW) ? cmem_rd[ROW_W-1:0] : r_mr;

    msp_ram #(
        .WIDTH (COL_W),
        .DEPTH (MAX_ROWS)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_we      (rmem_we),
        .i_wr_addr (r_row),
        .i_wr_data (n_min_col),
        .i_rd_addr (rmem_rd_addr),
        .o_rd_data (rmem_rd)
    );

    // Scan check: a hit is held back one step so the final one can carry last.
    assign out_free = !r_out_vld || !i_out_stall;
    assign hit      = (rmem_rd == r_x);
    assign chk_adv  = !(hit && r_pend_vld && !out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_row_count <= SIZE_W'(1);
            r_col_count <= SIZE_W'(1);
            r_row       <= '0;
            r_col       <= '0;
            r_min_col   <= '0;
            r_s1_vld    <= 1'b0;
            r_fw_vld    <= 1'b0;
            r_x         <= '0;
            r_pend_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            // Column store pipeline
            r_s1_vld  <= acc;
            r_s1_val  <= i_element_value;
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_fw_vld  <= upd;
            r_fw_addr <= r_s1_col;
            r_fw_data <= cmem_wr_data;

            // Drop the output word once taken
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_ACC: begin
                    if (acc) begin
                        r_min     <= take_min ? i_element_value : r_min;
                        r_min_col <= n_min_col;
                        if (r_col == last_col) begin
                            r_col <= '0;
                            if (r_row == last_row) begin
                                r_row   <= '0;
                                r_state <= S_DRAIN;
                            end else begin
                                r_row <= r_row + ROW_W'(1);
                            end
                        end else begin
                            r_col <= r_col + COL_W'(1);
                        end
                    end
                end
                S_DRAIN: begin
                    // Let the last column write land before scanning
                    r_x     <= '0;
                    r_state <= S_COL;
                end
                S_COL: begin
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    r_mr    <= cmem_rd[ROW_W-1:0];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (chk_adv) begin
                        if (hit) begin
                            if (r_pend_vld) begin
                                r_out_vld   <= 1'b1;
                                r_found     <= 1'b1;
                                r_point_row <= r_pend_row;
                                r_point_col <= r_pend_col;
                                r_last      <= 1'b0;
                            end
                            r_pend_vld <= 1'b1;
                            r_pend_row <= SIZE_W'(r_mr) + SIZE_W'(1);
                            r_pend_col <= SIZE_W'(r_x) + SIZE_W'(1);
                        end
                        if (r_x == last_col) begin
                            r_state <= S_FIN;
                        end else begin
                            r_x     <= r_x + COL_W'(1);
                            r_state <= S_COL;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_vld   <= 1'b1;
                        r_found     <= r_pend_vld;
                        r_point_row <= r_pend_vld ? r_pend_row : '0;
                        r_point_col <= r_pend_vld ? r_pend_col : '0;
                        r_last      <= 1'b1;
                        r_pend_vld  <= 1'b0;
                        r_x         <= '0;
                        r_state     <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase

            // Register write: restart the matrix
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_ROW_COUNT: r_row_count <= pwdata[SIZE_W-1:0];
                    REG_COL_COUNT: r_col_count <= pwdata[SIZE_W-1:0];
                    default:       r_row_count <= r_row_count;
                endcase
                r_row <= '0;
                r_col <= '0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_found     = r_found;
    assign o_point_row = r_point_row;
    assign o_point_col = r_point_col;
    assign o_last      = r_last;

endmodule

// File: hdl/msp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on an address collision. No dependencies.
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: tb/saddle_point_board_pkg.sv
`timescale 1ns / 100ps
// Result predictor and checker for the matrix saddle point finder testbench.
// Depends on msp_pkg for sizes and register indexes.
package saddle_point_board_pkg;
    import msp_pkg::*;

    typedef struct packed {
        logic              found;
        logic [SIZE_W-1:0] row;
        logic [SIZE_W-1:0] col;
        logic              last;
    } t_saddle_word;

    class saddle_point_board;
        // size registers as written, counters, per-column and per-row stores
        logic [SIZE_W-1:0]        rows_reg;
        logic [SIZE_W-1:0]        cols_reg;
        int unsigned              row_idx;
        int unsigned              col_idx;
        logic signed [DATA_W-1:0] col_max_val [MAX_COLS];
        logic [ROW_W-1:0]         col_max_row [MAX_COLS];
        logic [COL_W-1:0]         row_min_col [MAX_ROWS];
        logic signed [DATA_W-1:0] row_min_val;
        logic [COL_W-1:0]         row_min_at;
        t_saddle_word             pending_points [$];
        int                       mismatches;

        function new();
            rows_reg    = SIZE_W'(1);
            cols_reg    = SIZE_W'(1);
            row_idx     = 0;
            col_idx     = 0;
            row_min_val = '0;
            row_min_at  = '0;
            mismatches  = 0;
            foreach (col_max_val[k]) begin
                col_max_val[k] = '0;
                col_max_row[k] = '0;
            end
            foreach (row_min_col[k]) row_min_col[k] = '0;
        endfunction

        function int unsigned clamp_size(logic [SIZE_W-1:0] raw, int unsigned hi);
            if (raw == 0) return 1;
            if (raw > hi) return hi;
            return raw;
        endfunction

        // any size write restarts the matrix
        function void write_size(logic idx, logic [SIZE_W-1:0] val);
            if (idx == REG_ROW_COUNT) rows_reg = val;
            else cols_reg = val;
            row_idx = 0;
            col_idx = 0;
        endfunction

        function void take_element(logic signed [DATA_W-1:0] v);
            int unsigned  rows, cols, r, c, x, hits;
            logic [ROW_W-1:0] mr;
            t_saddle_word w;
            rows = clamp_size(rows_reg, MAX_ROWS);
            cols = clamp_size(cols_reg, MAX_COLS);
            r = row_idx;
            c = col_idx;
            if (r >= rows) r = 0;
            if (c >= cols) c = 0;
            if (r == 0 || v > col_max_val[c]) begin
                col_max_val[c] = v;
                col_max_row[c] = ROW_W'(r);
            end
            if (c == 0 || v < row_min_val) begin
                row_min_val = v;
                row_min_at  = COL_W'(c);
            end
            if (c + 1 < cols) begin
                row_idx = r;
                col_idx = c + 1;
                return;
            end
            row_min_col[r] = row_min_at;
            col_idx = 0;
            if (r + 1 < rows) begin
                row_idx = r + 1;
                return;
            end
            row_idx = 0;
            // report scan over the columns, in order
            hits = 0;
            for (x = 0; x < cols; x++) begin
                mr = col_max_row[x];
                if (row_min_col[mr] == x) begin
                    w.found = 1'b1;
                    w.row   = SIZE_W'(mr) + SIZE_W'(1);
                    w.col   = SIZE_W'(x + 1);
                    w.last  = 1'b0;
                    pending_points = {pending_points, w};
                    hits++;
                end
            end
            if (hits == 0) begin
                w = '0;
                w.last = 1'b1;
                pending_points = {pending_points, w};
            end else begin
                pending_points[pending_points.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_point(logic found, logic [SIZE_W-1:0] row,
                                  logic [SIZE_W-1:0] col, logic last);
            t_saddle_word want;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word found=%0b row=%0d col=%0d last=%0b",
                             $time, found, row, col, last);
                return;
            end
            want = pending_points.pop_front();
            if (want.found !== found || want.row !== row || want.col !== col ||
                want.last !== last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch expected found=%0b row=%0d col=%0d last=%0b",
                             $time, want.found, want.row, want.col, want.last);
                    $display("%0t:          got      found=%0b row=%0d col=%0d last=%0b",
                             $time, found, row, col, last);
                end
            end
        endfunction

        function int pending();
            return pending_points.size();
        endfunction
    endclass
endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench: streams matrices into matrix_saddle_point_finder and checks reports.
// Depends on msp_pkg and saddle_point_board_pkg.
module tb_top;
    import msp_pkg::*;
    import saddle_point_board_pkg::*;

    // Cycles with no accepted word on any port before the run is stopped as failed.
    // Worst legal stretch: a 64-column scan with heavy output stall plus the
    // long hold-off below, well under this.
    localparam int STUCK_LIMIT = 4000;
    // Report scan of the widest matrix: drain, column/row read and check per column, final word.
    localparam int SCAN_TAIL   = 3 * MAX_COLS + 8;
    // Column store read-modify-write settles within this after the last element.
    localparam int RMW_TAIL    = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 410;

    typedef enum {PH_SRC_LIGHT, PH_SNK_LIGHT, PH_NO_IDLE} t_idle_phase;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [DATA_W-1:0]   i_element_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_found;
    logic [SIZE_W-1:0]          o_point_row;
    logic [SIZE_W-1:0]          o_point_col;
    logic                       o_last;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_AW-1:0]          paddr = '0;
    logic [APB_DW-1:0]          pwdata = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    saddle_point_board sb = new();

    t_idle_phase idle_phase = PH_SRC_LIGHT;
    int unsigned src_idle_pct = 11;
    int unsigned snk_idle_pct = 81;
    int unsigned cur_rows = 1;
    int unsigned cur_cols = 1;
    int          stuck_cycles = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    matrix_saddle_point_finder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_element_value(i_element_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_point_row    (o_point_row),
        .o_point_col    (o_point_col),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // Monitor: everything is sampled in the active region right after the edge,
    // so it sees the values that the block saw at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            bit took;
            took = 1'b0;
            // note size writes first so the predictor restarts in step with the block
            if (psel && penable && pwrite && pready) begin
                sb.write_size(paddr[APB_AW-1], pwdata[SIZE_W-1:0]);
                took = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                sb.take_element(i_element_value);
                took = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_point(o_found, o_point_row, o_point_col, o_last);
                took = 1'b1;
            end
            stuck_cycles = took ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Receiver: random stall, plus one long hold-off once idling is off so the
    // block backs up and stalls its input while the sender keeps offering.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_phase == PH_NO_IDLE && !hold_done && o_out_valid) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < snk_idle_pct);
        end
    end

    task automatic set_idle(input t_idle_phase ph);
        idle_phase = ph;
        case (ph)
            PH_SRC_LIGHT: begin
                src_idle_pct = 11;
                snk_idle_pct = 81;
            end
            PH_SNK_LIGHT: begin
                src_idle_pct = 81;
                snk_idle_pct = 11;
            end
            default: begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one element word; return at the edge that accepts it with valid
    // still high, so a following word goes out back to back.
    task automatic send_element(input logic signed [DATA_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_element_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected word is in, then let the
    // column store finish its last write.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (RMW_TAIL) @(posedge i_clk);
    endtask

    // Setup phase, then access phase, then back to idle;
    // junk in the upper data bits must be ignored.
    task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] val);
        logic [APB_DW-1:0] junk;
        junk    = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[APB_DW-1:SIZE_W], val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] raw_rows,
                            input logic [SIZE_W-1:0] raw_cols);
        settle();
        if ($urandom_range(1)) begin
            write_reg(REG_ROW_COUNT, raw_rows);
            write_reg(REG_COL_COUNT, raw_cols);
        end else begin
            write_reg(REG_COL_COUNT, raw_cols);
            write_reg(REG_ROW_COUNT, raw_rows);
        end
        // zero acts as one, anything past the maximum acts as the maximum
        cur_rows = (raw_rows == 0) ? 1 : (raw_rows > MAX_ROWS) ? MAX_ROWS : raw_rows;
        cur_cols = (raw_cols == 0) ? 1 : (raw_cols > MAX_COLS) ? MAX_COLS : raw_cols;
    endtask

    // Narrow values make ties and saddle points common; full-range and
    // extreme values exercise every bit and the signed compares.
    function automatic logic signed [DATA_W-1:0] pick_element();
        logic [DATA_W-1:0] raw;
        case ($urandom_range(9))
            0, 1, 2: raw = $urandom();
            3: begin
                case ($urandom_range(3))
                    0: raw = 32'h8000_0000;
                    1: raw = 32'h7FFF_FFFF;
                    2: raw = '0;
                    default: raw = '1;
                endcase
            end
            default: raw = DATA_W'($urandom_range(8)) - DATA_W'(4);
        endcase
        return raw;
    endfunction

    task automatic run_random(input int goal);
        int                sent, n;
        bit                must_restart;
        logic [SIZE_W-1:0] raw_rows, raw_cols;
        sent = 0;
        must_restart = 1'b0;
        while (sent < goal) begin
            if (sent >= 2 * goal / 3) set_idle(PH_NO_IDLE);
            else if (sent >= goal / 3) set_idle(PH_SNK_LIGHT);
            if (must_restart || $urandom_range(99) < 30) begin
                if ($urandom_range(99) < 4) begin
                    // tall or wide extreme, with some writes past the maximum
                    if ($urandom_range(1)) begin
                        raw_rows = SIZE_W'($urandom_range(MAX_ROWS, 127));
                        raw_cols = SIZE_W'($urandom_range(1, 2));
                    end else begin
                        raw_rows = SIZE_W'($urandom_range(1, 2));
                        raw_cols = SIZE_W'($urandom_range(MAX_COLS, 127));
                    end
                end else begin
                    raw_rows = ($urandom_range(99) < 5) ? SIZE_W'(0)
                                                        : SIZE_W'($urandom_range(1, 6));
                    raw_cols = ($urandom_range(99) < 5) ? SIZE_W'(0)
                                                        : SIZE_W'($urandom_range(1, 6));
                end
                set_size(raw_rows, raw_cols);
                must_restart = 1'b0;
            end
            n = cur_rows * cur_cols;
            // broken matrix: stop early, the next size write restarts it
            if (n > 1 && $urandom_range(99) < 8) begin
                n = $urandom_range(1, n - 1);
                must_restart = 1'b1;
            end
            repeat (n) send_element(pick_element());
            sent += n;
            if (must_restart) settle();
        end
    endtask

    initial begin
        set_idle(PH_SRC_LIGHT);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one by one after reset: every element is its own saddle point
        send_element(32'sh8000_0000);
        send_element(32'sh7FFF_FFFF);
        // zero sizes act as one
        set_size(7'd0, 7'd0);
        send_element(-32'sd1);
        // all equal: ties keep the first row and column, one report
        set_size(7'd2, 7'd2);
        send_element(32'sd5);
        send_element(32'sd5);
        send_element(32'sd5);
        send_element(32'sd5);
        // no saddle point at all
        send_element(32'sd1);
        send_element(32'sd2);
        send_element(32'sd2);
        send_element(32'sd1);
        // start a matrix, then resize mid-way: the partial elements are dropped
        set_size(7'd3, 7'd3);
        send_element(32'sd7);
        send_element(-32'sd7);
        set_size(7'd3, 7'd2);
        send_element(32'sd1);
        send_element(32'sd2);
        send_element(32'sd3);
        send_element(32'sd4);
        send_element(32'sd0);
        send_element(32'sd9);

        run_random(RANDOM_ITEMS);

        // drain: wait out all reports, then the longest scan
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SCAN_TAIL) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
